// ===== design/frm_pkg.sv =====
`timescale 1ns / 1ps

package frm_pkg;

	// Configuration port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FRAME_TICKS = 1'd1;

	localparam logic [CFG_W-1:0] TICKS_PER_SECOND_RESET   = 32'd1000000;
	localparam logic [CFG_W-1:0] TARGET_FRAME_TICKS_RESET = 32'd16667;

	// Request mode codes
	localparam logic MODE_FRAME   = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	// Result widths and arithmetic constants
	localparam int FPS_W  = 24;
	localparam int PROD_W = 2 * CFG_W;

	// Average divides by ten; new sample weight one, old weight nine
	localparam int                  EMA_DEN_W = 4;
	localparam logic [EMA_DEN_W-1:0] EMA_DEN  = 4'd10;

	// Divide by ten one 20-bit digit at a time: floor(n/10) = (n * RECIP) >> 27, n < 2^26
	localparam int                   EMA_DIG_W    = 20;
	localparam int                   EMA_CUR_W    = EMA_DEN_W + EMA_DIG_W;
	localparam logic [EMA_CUR_W-1:0] EMA_RECIP    = 24'hCCCCCD;
	localparam int                   EMA_RECIP_SH = 27;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic restart_load;
		logic frame_step;
		logic mul;
		logic start;
		logic commit;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic restart;
		logic ema_busy;
		logic fps_busy;
	} ctrl_status_t;

endpackage

// ===== design/frm_in_if.sv =====
`timescale 1ns / 1ps

interface frm_in_if #(
	parameter int TIME_BITS = 48
);
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [TIME_BITS-1:0] timestamp;

	modport source (output valid, output mode, output timestamp, input ready);
	modport sink (input valid, input mode, input timestamp, output ready);
endinterface

// ===== design/frm_out_if.sv =====
`timescale 1ns / 1ps

interface frm_out_if #(
	parameter int SP_BITS = 56
);
	logic               valid;
	logic               ready;
	logic [SP_BITS-1:0] smoothed_frame_time;
	logic [23:0]        average_fps;
	logic               fps_updated;

	modport source (
		output valid, output smoothed_frame_time, output average_fps,
		output fps_updated, input ready
	);
	modport sink (
		input valid, input smoothed_frame_time, input average_fps,
		input fps_updated, output ready
	);
endinterface

// ===== design/frm_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module frm_div #(
	parameter int NUM_W = 60,
	parameter int DEN_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// Shift in the next numerator bit and try a subtract
	assign trial = {rem_q, work_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// Count steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Quotient bits enter at the bottom as the numerator leaves the top
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = work_q;
endmodule

// ===== design/frm_datapath.sv =====
`timescale 1ns / 1ps

module frm_datapath #(
	parameter int TIME_BITS = 48,
	parameter int FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [frm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [frm_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_mode,
	input  logic [TIME_BITS-1:0]                in_timestamp,
	input  frm_pkg::ctrl_cmd_t                  cmd,
	output frm_pkg::ctrl_status_t               status,
	output logic [TIME_BITS+FRAC_BITS-1:0]      out_sp,
	output logic [frm_pkg::FPS_W-1:0]           out_fps,
	output logic                                out_upd
);
	import frm_pkg::*;

	localparam int SP_W   = TIME_BITS + FRAC_BITS;
	localparam int SUM_W  = SP_W + 4;
	localparam int FNUM_W = PROD_W + FRAC_BITS;
	localparam int CMP_W  = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	localparam int EMA_DIGITS = (SUM_W + EMA_DIG_W - 1) / EMA_DIG_W;
	localparam int EMA_NUM_W  = EMA_DIGITS * EMA_DIG_W;
	localparam int EMA_CNT_W  = $clog2(EMA_DIGITS + 1);

	// Configuration and architectural state
	logic [CFG_W-1:0]     tps_q;
	logic [CFG_W-1:0]     tgt_q;
	logic [TIME_BITS-1:0] frame_start_q;
	logic [TIME_BITS-1:0] window_start_q;
	logic [CFG_W-1:0]     frames_q;
	logic [SP_W-1:0]      smoothed_q;
	logic [FPS_W-1:0]     fps_q;

	// Captured request and working registers
	logic                 mode_q;
	logic [TIME_BITS-1:0] ts_q;
	logic                 upd_q;
	logic [TIME_BITS-1:0] delta_s1;
	logic [TIME_BITS-1:0] elapsed_s1;
	logic [SUM_W-1:0]     nine_s1;
	logic [SUM_W-1:0]     sum_s2;
	logic [PROD_W-1:0]    prod_s2;

	// Divide-by-ten sequencer
	logic [EMA_NUM_W-1:0]   ema_work_q;
	logic [EMA_DEN_W-1:0]   ema_rem_q;
	logic [EMA_CNT_W-1:0]   ema_cnt_q;
	logic                   ema_busy_q;
	logic [EMA_CUR_W-1:0]   ema_cur;
	logic [2*EMA_CUR_W-1:0] ema_prod;
	logic [EMA_DIG_W-1:0]   ema_digit;
	logic [EMA_CUR_W-1:0]   ema_back;

	logic [CFG_W-1:0]  freq_eff;
	logic [CMP_W-1:0]  tgt_ext;
	logic              tgt_over;
	logic [SP_W-1:0]   tgt_scaled;
	logic [SUM_W-1:0]  ema_quot;
	logic [FNUM_W-1:0] fps_num;
	logic [FNUM_W-1:0] fps_quot;
	logic [FPS_W-1:0]  fps_sat;
	logic              ema_busy;
	logic              fps_busy;

	// A zero frequency counts as one tick per second
	assign freq_eff = (tps_q == '0) ? CFG_W'(1) : tps_q;

	// Scale the target period, saturating to the smoothed width
	assign tgt_ext    = CMP_W'(tgt_q);
	assign tgt_over   = (tgt_ext >> TIME_BITS) != '0;
	assign tgt_scaled = tgt_over ? '1 : (SP_W'(tgt_ext[TIME_BITS-1:0]) << FRAC_BITS);

	assign fps_num = FNUM_W'(prod_s2) << FRAC_BITS;
	assign fps_sat = (fps_quot[FNUM_W-1:FPS_W] != '0) ? '1 : fps_quot[FPS_W-1:0];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TICKS_PER_SECOND_RESET;
			tgt_q <= TARGET_FRAME_TICKS_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_TICKS_PER_SECOND:   tps_q <= cfg_data;
				REG_TARGET_FRAME_TICKS: tgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Update time bases, frame count, average and FPS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q  <= '0;
			window_start_q <= '0;
			frames_q       <= '0;
			smoothed_q     <= SP_W'(TARGET_FRAME_TICKS_RESET) << FRAC_BITS;
			fps_q          <= '0;
		end else begin
			priority if (cmd.restart_load) begin
				frame_start_q  <= ts_q;
				window_start_q <= ts_q;
				frames_q       <= '0;
				smoothed_q     <= tgt_scaled;
				fps_q          <= '0;
			end else if (cmd.frame_step) begin
				frame_start_q <= ts_q;
				frames_q      <= frames_q + CFG_W'(1);
			end else if (cmd.start) begin
				if (upd_q) begin
					frames_q       <= '0;
					window_start_q <= ts_q;
				end
			end else if (cmd.commit) begin
				smoothed_q <= ema_quot[SP_W-1:0];
				if (upd_q) begin
					fps_q <= fps_sat;
				end
			end
		end
	end

	// Capture the request and run the arithmetic steps
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			ts_q   <= in_timestamp;
		end
		if (cmd.restart_load) begin
			upd_q <= 1'b0;
		end
		if (cmd.frame_step) begin
			delta_s1   <= ts_q - frame_start_q;
			elapsed_s1 <= ts_q - window_start_q;
			nine_s1    <= (SUM_W'(smoothed_q) << 3) + SUM_W'(smoothed_q);
		end
		if (cmd.mul) begin
			upd_q   <= CMP_W'(elapsed_s1) >= CMP_W'(freq_eff);
			prod_s2 <= PROD_W'(frames_q) * PROD_W'(freq_eff);
			sum_s2  <= (SUM_W'(delta_s1) << FRAC_BITS) + nine_s1;
		end
	end

	// Divide the next digit by ten: reciprocal multiply, then take back the remainder
	assign ema_cur   = {ema_rem_q, ema_work_q[EMA_NUM_W-1 -: EMA_DIG_W]};
	assign ema_prod  = ema_cur * EMA_RECIP;
	assign ema_digit = ema_prod[EMA_RECIP_SH +: EMA_DIG_W];
	assign ema_back  = ema_cur - EMA_CUR_W'(ema_digit) * EMA_CUR_W'(EMA_DEN);
	assign ema_quot  = ema_work_q[SUM_W-1:0];
	assign ema_busy  = ema_busy_q;

	// Count digit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_busy_q <= 1'b0;
			ema_cnt_q  <= '0;
		end else if (cmd.start) begin
			ema_busy_q <= 1'b1;
			ema_cnt_q  <= EMA_CNT_W'(EMA_DIGITS);
		end else if (ema_busy_q) begin
			ema_cnt_q <= ema_cnt_q - EMA_CNT_W'(1);
			if (ema_cnt_q == EMA_CNT_W'(1)) begin
				ema_busy_q <= 1'b0;
			end
		end
	end

	// Quotient digits enter at the bottom as the numerator leaves the top
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ema_work_q <= EMA_NUM_W'(sum_s2);
			ema_rem_q  <= '0;
		end else if (ema_busy_q) begin
			ema_work_q <= (ema_work_q << EMA_DIG_W) | EMA_NUM_W'(ema_digit);
			ema_rem_q  <= ema_back[EMA_DEN_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_sp  <= smoothed_q;
			out_fps <= fps_q;
			out_upd <= upd_q;
		end
	end

	frm_div #(
		.NUM_W(FNUM_W),
		.DEN_W(TIME_BITS)
	) u_fps_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start && upd_q),
		.num   (fps_num),
		.den   (elapsed_s1),
		.busy  (fps_busy),
		.quot  (fps_quot)
	);

	assign status.restart  = (mode_q == MODE_RESTART);
	assign status.ema_busy = ema_busy;
	assign status.fps_busy = fps_busy;
endmodule

// ===== design/frm_ctrl.sv =====
`timescale 1ns / 1ps

module frm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  frm_pkg::ctrl_status_t status,
	output frm_pkg::ctrl_cmd_t    cmd
);
	import frm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        out_free;
	logic        div_idle;

	assign out_free = !out_valid_q || out_ready;
	assign div_idle = !status.ema_busy && !status.fps_busy;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CALC;
			ST_CALC:  state_d = status.restart ? ST_EMIT : ST_MUL;
			ST_MUL:   state_d = ST_START;
			ST_START: state_d = ST_WAIT;
			ST_WAIT:  if (div_idle) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_CALC: begin
				cmd.restart_load = status.restart;
				cmd.frame_step   = !status.restart;
			end
			ST_MUL:   cmd.mul = 1'b1;
			ST_START: cmd.start = 1'b1;
			ST_WAIT:  cmd.commit = div_idle;
			ST_EMIT:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	// Hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request accepted while one is in flight");

	a_div_engaged: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START) |=> status.ema_busy)
		else $error("average divider did not start");

	a_wait_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && div_idle) |=> (state_q == ST_EMIT))
		else $error("controller missed divider completion");
`endif
endmodule

// ===== design/frame_rate_monitor.sv =====
// Frame rate monitor. Each request on events carries a tick timestamp and a mode:
// frame start updates the smoothed frame period, floor((delta*2^FRAC_BITS +
// 9*old)/10) in Q.FRAC_BITS ticks, and once ticks_per_second ticks have passed
// since the window began it closes the window with frames*freq/elapsed in
// Q16.8 (saturating) and flags fps_updated; restart sets both time bases,
// reloads the period from target_frame_ticks and clears the FPS. Send a restart
// first after reset. One result per request. One request is handled at a time:
// a restart passes through the capture, load and emit states, and a frame start
// through capture, step, multiply, divider start, a wait for the dividers, and
// emit. The divide by ten for the average runs one 20-bit digit per cycle by
// reciprocal multiplication; a window close also runs the bit-serial restoring
// FPS divider beside it, at one quotient bit per cycle. The next request is
// taken while the previous result waits in the output register. Write the
// configuration registers only while the block is idle.
`timescale 1ns / 1ps

module frame_rate_monitor #(
	parameter int TIME_BITS = 48,
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [frm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [frm_pkg::CFG_W-1:0]     cfg_data,
	frm_in_if.sink                        events,
	frm_out_if.source                     results
);
	import frm_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	logic [TIME_BITS+FRAC_BITS-1:0] out_sp;
	logic [FPS_W-1:0]               out_fps;
	logic                           out_upd;
	logic                           out_valid;
	logic                           in_ready;

	frm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (events.valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(results.ready),
		.status   (status),
		.cmd      (cmd)
	);

	frm_datapath #(
		.TIME_BITS(TIME_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_mode     (events.mode),
		.in_timestamp(events.timestamp),
		.cmd         (cmd),
		.status      (status),
		.out_sp      (out_sp),
		.out_fps     (out_fps),
		.out_upd     (out_upd)
	);

	assign events.ready                = in_ready;
	assign results.valid               = out_valid;
	assign results.smoothed_frame_time = out_sp;
	assign results.average_fps         = out_fps;
	assign results.fps_updated         = out_upd;
endmodule
